// ===== rtl/core/tmon_pkg.sv =====
// Shared types, codes and constants of the thermistor monitor.
package tmon_pkg;

    localparam int ADC_BITS = 10;
    localparam int TOD_BITS = 17;
    localparam int TEMP_BITS = 14;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [ADC_BITS-1:0] ADC_MAX = {ADC_BITS{1'b1}};

    // Item kinds on the input channel.
    localparam logic [1:0] MODE_CMD = 2'd0;
    localparam logic [1:0] MODE_TICK = 2'd1;
    localparam logic [1:0] MODE_BUTTON = 2'd2;

    // Result kinds.
    localparam logic KIND_TEMP = 1'b0;
    localparam logic KIND_SHUTDOWN = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_INITIAL_PERIOD = 1'b0;
    localparam logic CFG_INITIAL_SCALE_F = 1'b1;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;

    // Keyword slots in the match mask.
    localparam int KW_COUNT = 6;
    localparam int KW_SCALE_F = 0;
    localparam int KW_SCALE_C = 1;
    localparam int KW_START = 2;
    localparam int KW_STOP = 3;
    localparam int KW_OFF = 4;
    localparam int KW_PERIOD = 5;
    localparam logic [3:0] PERIOD_PREFIX = 4'd7;
    localparam logic [3:0] LINE_POS_MAX = 4'd8;

    // Keyword text, left aligned, first character in the top byte.
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        {"SCALE=F", 8'h00},
        {"SCALE=C", 8'h00},
        {"START", 24'h000000},
        {"STOP", 32'h00000000},
        {"OFF", 40'h0000000000},
        {"PERIOD=", 8'h00}
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd7, 4'd7, 4'd5, 4'd4, 4'd3, 4'd7};

    // Beta equation constants.
    localparam logic [29:0] LN2_Q30 = 30'd744261118;
    localparam logic [14:0] T0_CENTI = 15'd29815;
    localparam logic signed [45:0] DEN_BASE = 46'sd427500 <<< 24;
    localparam logic [63:0] KELVIN_NUM = 64'd127459125000 << 24;
    localparam logic signed [20:0] ZERO_C_MILLI = 21'sd273150;
    localparam int LOG_STEPS = 24;
    localparam int DIV_STEPS = 20;

    // Reciprocals of the final divisors, scaled by 2^RECIP_SHIFT and rounded up.
    // They give exact quotients for dividends below 2^24.
    localparam int RECIP_SHIFT = 32;
    localparam logic [25:0] RECIP_100 = 26'd42949673;
    localparam logic [25:0] RECIP_500 = 26'd8589935;

    // One unit of work handed from the front to the back.
    typedef struct packed {
        logic                kind;
        logic                scale_f;
        logic [ADC_BITS-1:0] reading;
        logic [TOD_BITS-1:0] tod;
    } job_t;

    function automatic logic [7:0] kw_char(input logic [63:0] text, input logic [2:0] pos);
        logic [63:0] t;
        t = text << {pos, 3'b000};
        return t[63:56];
    endfunction

endpackage

// ===== rtl/core/thermistor_monitor_with_commands.sv =====
// Top level of the thermistor monitor with its command-line front end.
//
// The block takes one item per cycle at its input while its job queue has room:
// command bytes are handled in the front, a button press or an OFF command queues
// a shutdown notice, and a tick that calls for a report queues a conversion job.
// After its job leaves the queue the back works it through two 24-step
// logarithms, a natural-log step, a denominator step, a 20-step restoring division
// for the Kelvin value, one scaling step and one reciprocal multiplication that
// rounds to tenths, and then offers the report. Rail readings skip the logarithms
// and the division and go from the queue straight to the scaling step; a shutdown
// notice is offered in the cycle after it leaves the queue.
// The back works on one job at a time and passes through idle after each result
// is taken, so reports leave one at a time; the two-entry queue lets commands
// keep flowing while a report is in work or waits at the output, and the input
// stalls only while the queue is full. Results use the valid/stall handshake and
// stay stable while stalled. After a shutdown notice the block drops every item
// until reset.
module thermistor_monitor_with_commands #(
    parameter int PERIOD_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [1:0]                            mode,
    input  logic [7:0]                            cmd_byte,
    input  logic [tmon_pkg::ADC_BITS-1:0]         adc_reading,
    input  logic [tmon_pkg::TOD_BITS-1:0]         time_of_day,
    input  logic                                  cfg_we,
    input  logic                                  cfg_index,
    input  logic [tmon_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  report_kind,
    output logic [tmon_pkg::TOD_BITS-1:0]         report_time,
    output logic signed [tmon_pkg::TEMP_BITS-1:0] temp_tenths
);

    logic           push;
    tmon_pkg::job_t push_job;
    logic           pop;
    tmon_pkg::job_t pop_job;
    logic           q_empty;
    logic           q_full;

    // The front owns all command, period and tick state.
    tmon_front #(
        .PERIOD_WIDTH(PERIOD_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .cmd_byte   (cmd_byte),
        .adc_reading(adc_reading),
        .time_of_day(time_of_day),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .push       (push),
        .push_job   (push_job)
    );

    // Jobs carry the scale in force when they were issued.
    tmon_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_job(push_job),
        .pop     (pop),
        .pop_job (pop_job),
        .empty   (q_empty),
        .full    (q_full)
    );

    tmon_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_job      (pop_job),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .report_kind(report_kind),
        .report_time(report_time),
        .temp_tenths(temp_tenths)
    );

endmodule

// ===== rtl/core/tmon_front.sv =====
// Front end: accepts items, parses command lines, counts ticks and issues jobs.
module tmon_front #(
    parameter int PERIOD_WIDTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         mode,
    input  logic [7:0]                         cmd_byte,
    input  logic [tmon_pkg::ADC_BITS-1:0]      adc_reading,
    input  logic [tmon_pkg::TOD_BITS-1:0]      time_of_day,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [tmon_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                               q_full,
    output logic                               push,
    output tmon_pkg::job_t                     push_job
);

    localparam logic [PERIOD_WIDTH-1:0] PMAX = {PERIOD_WIDTH{1'b1}};

    logic                    scale_reg, scale_next;
    logic [PERIOD_WIDTH-1:0] period_reg, period_next;
    logic                    running_reg, running_next;
    logic [PERIOD_WIDTH-1:0] ticks_reg, ticks_next;
    logic [5:0]              mask_reg, mask_next;
    logic [3:0]              pos_reg, pos_next;
    logic [PERIOD_WIDTH-1:0] acc_reg, acc_next;
    logic [1:0]              phase_reg, phase_next;
    logic                    neg_reg, neg_next;
    logic                    halted_reg, halted_next;

    logic                    accept;
    logic                    is_digit;
    logic                    is_space;
    logic [32:0]             cfg_ext;
    logic [PERIOD_WIDTH+3:0] acc_mul;
    logic [PERIOD_WIDTH-1:0] tick_inc;
    logic                    keep;

    assign in_stall = q_full;
    assign accept = in_valid && !q_full;
    assign is_digit = (cmd_byte >= 8'd48) && (cmd_byte <= 8'd57);
    assign is_space = (cmd_byte == 8'd32) || ((cmd_byte >= 8'd9) && (cmd_byte <= 8'd13));
    assign cfg_ext = 33'(cfg_data);
    assign acc_mul = (PERIOD_WIDTH+4)'(acc_reg) * (PERIOD_WIDTH+4)'(10)
                     + (PERIOD_WIDTH+4)'(cmd_byte[3:0]);
    assign tick_inc = (ticks_reg < PMAX) ? ticks_reg + 1'b1 : ticks_reg;

    always_comb
    begin
        scale_next = scale_reg;
        period_next = period_reg;
        running_next = running_reg;
        ticks_next = ticks_reg;
        mask_next = mask_reg;
        pos_next = pos_reg;
        acc_next = acc_reg;
        phase_next = phase_reg;
        neg_next = neg_reg;
        halted_next = halted_reg;
        keep = 1'b0;
        push = 1'b0;
        push_job.kind = tmon_pkg::KIND_SHUTDOWN;
        push_job.scale_f = scale_reg;
        push_job.reading = adc_reading;
        push_job.tod = time_of_day;

        if (cfg_we)
        begin
            unique case (cfg_index)
                tmon_pkg::CFG_INITIAL_PERIOD:
                begin
                    if (cfg_ext > 33'(PMAX))
                        period_next = PMAX;
                    else
                        period_next = cfg_ext[PERIOD_WIDTH-1:0];
                end
                tmon_pkg::CFG_INITIAL_SCALE_F: scale_next = cfg_data[0];
            endcase
        end
        else if (accept && !halted_reg)
        begin
            unique case (mode)
                tmon_pkg::MODE_CMD:
                begin
                    if (cmd_byte == tmon_pkg::CHAR_NEWLINE)
                    begin
                        // First matching keyword wins, in this order.
                        priority if (mask_reg[tmon_pkg::KW_SCALE_F] && pos_reg == 4'd7)
                            scale_next = 1'b1;
                        else if (mask_reg[tmon_pkg::KW_SCALE_C] && pos_reg == 4'd7)
                            scale_next = 1'b0;
                        else if (mask_reg[tmon_pkg::KW_PERIOD] &&
                                 pos_reg >= tmon_pkg::PERIOD_PREFIX)
                            period_next = neg_reg ? '0 : acc_reg;
                        else if (mask_reg[tmon_pkg::KW_START] && pos_reg == 4'd5)
                            running_next = 1'b1;
                        else if (mask_reg[tmon_pkg::KW_STOP] && pos_reg == 4'd4)
                            running_next = 1'b0;
                        else if (mask_reg[tmon_pkg::KW_OFF] && pos_reg == 4'd3)
                        begin
                            halted_next = 1'b1;
                            push = 1'b1;
                        end
                        else
                        begin
                            // A line that matches no command is dropped.
                        end
                        mask_next = '1;
                        pos_next = '0;
                        acc_next = '0;
                        phase_next = 2'd0;
                        neg_next = 1'b0;
                    end
                    else
                    begin
                        for (int i = 0; i < tmon_pkg::KW_COUNT; i++)
                        begin
                            keep = ((pos_reg < tmon_pkg::KW_LEN[i]) &&
                                    (cmd_byte == tmon_pkg::kw_char(tmon_pkg::KW_TEXT[i],
                                                                   pos_reg[2:0]))) ||
                                   ((i == tmon_pkg::KW_PERIOD) &&
                                    (pos_reg >= tmon_pkg::PERIOD_PREFIX));
                            mask_next[i] = mask_reg[i] && keep;
                        end
                        if (pos_reg >= tmon_pkg::PERIOD_PREFIX)
                        begin
                            // Number after PERIOD=: spaces, optional sign, digits.
                            if (phase_reg == 2'd0)
                            begin
                                if (!is_space)
                                begin
                                    if (cmd_byte == 8'd43 || cmd_byte == 8'd45)
                                    begin
                                        neg_next = (cmd_byte == 8'd45);
                                        phase_next = 2'd1;
                                    end
                                    else if (is_digit)
                                    begin
                                        acc_next = PERIOD_WIDTH'(cmd_byte[3:0]);
                                        phase_next = 2'd1;
                                    end
                                    else
                                        phase_next = 2'd2;
                                end
                            end
                            else if (phase_reg == 2'd1)
                            begin
                                if (is_digit)
                                    acc_next = (acc_mul > (PERIOD_WIDTH+4)'(PMAX)) ?
                                               PMAX : acc_mul[PERIOD_WIDTH-1:0];
                                else
                                    phase_next = 2'd2;
                            end
                        end
                        if (pos_reg < tmon_pkg::LINE_POS_MAX)
                            pos_next = pos_reg + 4'd1;
                    end
                end
                tmon_pkg::MODE_TICK:
                begin
                    if (running_reg && tick_inc >= period_reg)
                    begin
                        ticks_next = '0;
                        push = 1'b1;
                        push_job.kind = tmon_pkg::KIND_TEMP;
                    end
                    else
                        ticks_next = tick_inc;
                end
                tmon_pkg::MODE_BUTTON:
                begin
                    halted_next = 1'b1;
                    push = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= 1'b1;
            period_reg <= PERIOD_WIDTH'(1);
            running_reg <= 1'b1;
            ticks_reg <= '0;
            mask_reg <= '1;
            pos_reg <= '0;
            acc_reg <= '0;
            phase_reg <= 2'd0;
            neg_reg <= 1'b0;
            halted_reg <= 1'b0;
        end
        else
        begin
            scale_reg <= scale_next;
            period_reg <= period_next;
            running_reg <= running_next;
            ticks_reg <= ticks_next;
            mask_reg <= mask_next;
            pos_reg <= pos_next;
            acc_reg <= acc_next;
            phase_reg <= phase_next;
            neg_reg <= neg_next;
            halted_reg <= halted_next;
        end
    end

endmodule

// ===== rtl/core/tmon_queue.sv =====
// Two-entry job queue between the front and the back.
module tmon_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tmon_pkg::job_t push_job,
    input  logic           pop,
    output tmon_pkg::job_t pop_job,
    output logic           empty,
    output logic           full
);

    tmon_pkg::job_t slot_reg [2];
    logic           wr_reg, wr_next;
    logic           rd_reg, rd_next;
    logic [1:0]     count_reg, count_next;

    assign empty = (count_reg == 2'd0);
    assign full = (count_reg == 2'd2);
    assign pop_job = slot_reg[rd_reg];

    always_comb
    begin
        wr_next = wr_reg;
        rd_next = rd_reg;
        count_next = count_reg;
        if (push && !full)
        begin
            wr_next = !wr_reg;
            count_next = count_next + 2'd1;
        end
        if (pop && !empty)
        begin
            rd_next = !rd_reg;
            count_next = count_next - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
            slot_reg[wr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= 1'b0;
            rd_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/core/tmon_back.sv =====
// Back end: beta-equation conversion with one log unit shared by both logarithms, a divider and a result register.
module tmon_back (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  q_empty,
    input  tmon_pkg::job_t                        q_job,
    output logic                                  pop,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  report_kind,
    output logic [tmon_pkg::TOD_BITS-1:0]         report_time,
    output logic signed [tmon_pkg::TEMP_BITS-1:0] temp_tenths
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_LOG   = 8'b00000010,
        S_LN    = 8'b00000100,
        S_DEN   = 8'b00001000,
        S_DIV   = 8'b00010000,
        S_SCALE = 8'b00100000,
        S_RECIP = 8'b01000000,
        S_OUT   = 8'b10000000
    } state_t;

    state_t                     state_reg, state_next;
    logic [4:0]                 cnt_reg, cnt_next;
    logic                       pass_reg, pass_next;
    logic [31:0]                m_reg, m_next;
    logic [23:0]                frac_reg, frac_next;
    logic [3:0]                 k_reg, k_next;
    logic [27:0]                la_reg, la_next;
    logic signed [28:0]         lnq_reg, lnq_next;
    logic [63:0]                rem_reg, rem_next;
    logic [63:0]                dsh_reg, dsh_next;
    logic [19:0]                quot_reg, quot_next;
    logic                       neg_reg, neg_next;
    logic signed [20:0]         c_reg, c_next;
    logic [tmon_pkg::ADC_BITS-1:0] rd_reg, rd_next;
    logic                       scale_reg, scale_next;
    logic                       kind_reg, kind_next;
    logic [tmon_pkg::TOD_BITS-1:0] tod_reg, tod_next;
    logic signed [tmon_pkg::TEMP_BITS-1:0] temp_reg, temp_next;

    logic [tmon_pkg::ADC_BITS-1:0] log_n;
    logic [3:0]                 log_k;
    logic [63:0]                sq;
    logic [31:0]                sq_s;
    logic [23:0]                frac_step;
    logic signed [28:0]         d;
    logic [27:0]                mag;
    logic [57:0]                ln_prod;
    logic signed [45:0]         den_s;
    logic [43:0]                den;
    logic                       ge;
    logic [19:0]                quot_step;
    logic signed [24:0]         v;
    logic [23:0]                vmag;
    logic [49:0]                recip_prod;

    assign out_valid = (state_reg == S_OUT);
    assign report_kind = kind_reg;
    assign report_time = tod_reg;
    assign temp_tenths = temp_reg;

    // Leading-one position of the log operand.
    always_comb
    begin
        log_k = '0;
        for (int i = 0; i < tmon_pkg::ADC_BITS; i++)
            if (log_n[i])
                log_k = 4'(i);
    end

    assign sq = 64'(m_reg) * 64'(m_reg);
    assign sq_s = sq[61:30];
    assign frac_step = {frac_reg[22:0], sq_s[31]};
    assign d = $signed({1'b0, la_reg}) - $signed({1'b0, k_reg, frac_reg});
    assign mag = d[28] ? 28'(-d) : d[27:0];
    assign ln_prod = 58'(mag) * 58'(tmon_pkg::LN2_Q30) + 58'(1 << 29);
    assign den_s = tmon_pkg::DEN_BASE + $signed({1'b0, tmon_pkg::T0_CENTI}) * lnq_reg;
    assign den = den_s[43:0];
    assign ge = (rem_reg >= dsh_reg);
    assign quot_step = {quot_reg[18:0], ge};
    assign v = scale_reg ? 25'(c_reg) * 25'sd9 + 25'sd160000 : 25'(c_reg);
    assign vmag = v[24] ? 24'(-v) : v[23:0];
    assign recip_prod = 50'(rem_reg[23:0]) *
                        50'(scale_reg ? tmon_pkg::RECIP_500 : tmon_pkg::RECIP_100);

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        pass_next = pass_reg;
        m_next = m_reg;
        frac_next = frac_reg;
        k_next = k_reg;
        la_next = la_reg;
        lnq_next = lnq_reg;
        rem_next = rem_reg;
        dsh_next = dsh_reg;
        quot_next = quot_reg;
        neg_next = neg_reg;
        c_next = c_reg;
        rd_next = rd_reg;
        scale_next = scale_reg;
        kind_next = kind_reg;
        tod_next = tod_reg;
        temp_next = temp_reg;
        pop = 1'b0;
        log_n = (state_reg == S_IDLE) ? tmon_pkg::ADC_MAX - q_job.reading : rd_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    pop = 1'b1;
                    kind_next = q_job.kind;
                    tod_next = q_job.tod;
                    scale_next = q_job.scale_f;
                    rd_next = q_job.reading;
                    if (q_job.kind == tmon_pkg::KIND_SHUTDOWN)
                    begin
                        temp_next = '0;
                        state_next = S_OUT;
                    end
                    else if (q_job.reading == '0 || q_job.reading == tmon_pkg::ADC_MAX)
                    begin
                        // Rail readings read as absolute zero.
                        c_next = -tmon_pkg::ZERO_C_MILLI;
                        state_next = S_SCALE;
                    end
                    else
                    begin
                        k_next = log_k;
                        m_next = 32'(log_n) << (5'd30 - 5'(log_k));
                        frac_next = '0;
                        cnt_next = '0;
                        pass_next = 1'b0;
                        state_next = S_LOG;
                    end
                end
            end
            S_LOG:
            begin
                // One squaring of the mantissa per cycle gives one fraction bit.
                m_next = sq_s[31] ? {1'b0, sq_s[31:1]} : sq_s;
                frac_next = frac_step;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(tmon_pkg::LOG_STEPS - 1))
                begin
                    if (!pass_reg)
                    begin
                        la_next = {k_reg, frac_step};
                        k_next = log_k;
                        m_next = 32'(log_n) << (5'd30 - 5'(log_k));
                        frac_next = '0;
                        cnt_next = '0;
                        pass_next = 1'b1;
                    end
                    else
                        state_next = S_LN;
                end
            end
            S_LN:
            begin
                lnq_next = d[28] ? -$signed({1'b0, ln_prod[57:30]})
                                 : $signed({1'b0, ln_prod[57:30]});
                state_next = S_DEN;
            end
            S_DEN:
            begin
                rem_next = tmon_pkg::KELVIN_NUM + 64'(den >> 1);
                dsh_next = 64'(den) << (tmon_pkg::DIV_STEPS - 1);
                quot_next = '0;
                cnt_next = '0;
                pass_next = 1'b0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (ge)
                    rem_next = rem_reg - dsh_reg;
                dsh_next = dsh_reg >> 1;
                quot_next = quot_step;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(tmon_pkg::DIV_STEPS - 1))
                begin
                    c_next = $signed({1'b0, quot_step}) - tmon_pkg::ZERO_C_MILLI;
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                // Half the divisor goes on the magnitude so the truncating
                // reciprocal product rounds half away from zero.
                neg_next = v[24];
                rem_next = 64'(vmag) + (scale_reg ? 64'd250 : 64'd50);
                state_next = S_RECIP;
            end
            S_RECIP:
            begin
                temp_next = neg_reg
                    ? -$signed(recip_prod[tmon_pkg::RECIP_SHIFT +: tmon_pkg::TEMP_BITS])
                    : $signed(recip_prod[tmon_pkg::RECIP_SHIFT +: tmon_pkg::TEMP_BITS]);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        pass_reg <= pass_next;
        m_reg <= m_next;
        frac_reg <= frac_next;
        k_reg <= k_next;
        la_reg <= la_next;
        lnq_reg <= lnq_next;
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quot_reg <= quot_next;
        neg_reg <= neg_next;
        c_reg <= c_next;
        rd_reg <= rd_next;
        scale_reg <= scale_next;
        kind_reg <= kind_next;
        tod_reg <= tod_next;
        temp_reg <= temp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== rtl/core/tmon_checker.sv =====
// Port-level assertions for the thermistor monitor and their bind.
module tmon_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  out_valid,
    input logic                                  out_stall,
    input logic                                  report_kind,
    input logic [tmon_pkg::TOD_BITS-1:0]         report_time,
    input logic signed [tmon_pkg::TEMP_BITS-1:0] temp_tenths
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(report_time) && $stable(temp_tenths)
                                   && $stable(report_kind))
        else $error("result changed while stalled");

    a_shutdown_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && report_kind == tmon_pkg::KIND_SHUTDOWN |-> temp_tenths == '0)
        else $error("shutdown notice with nonzero temperature");

    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && report_kind == tmon_pkg::KIND_TEMP
        |-> temp_tenths >= -14'sd4600 && temp_tenths <= 14'sd6000)
        else $error("temperature out of range");

endmodule

bind thermistor_monitor_with_commands tmon_checker u_tmon_checker (.*);
